FILE: rtl/core/sepq_pkg.sv
// ----------------------------------------------------------------------------
// sepq_pkg
// Shared types and constants for the sorted event priority queue.
// ----------------------------------------------------------------------------
package sepq_pkg;

    localparam int TIME_BITS     = 16;
    localparam int NODE_BITS     = 14;
    localparam int COUNT_W       = 7;
    localparam int QUEUE_DEPTH_D = 64;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [TIME_BITS-1:0] ev_time;
        logic [NODE_BITS-1:0] ev_node;
        logic                 ev_action;
    } entry_t;

    typedef struct packed
    {
        op_t                  op;
        logic [TIME_BITS-1:0] event_time;
        logic [NODE_BITS-1:0] event_node;
        logic                 event_action;
    } in_item_t;

    typedef struct packed
    {
        logic                 head_valid;
        logic [TIME_BITS-1:0] head_time;
        logic [NODE_BITS-1:0] head_node;
        logic                 head_action;
        logic [COUNT_W-1:0]   entry_count;
        logic                 underflow;
        logic                 overflow;
    } out_item_t;

    // broadcast from the top level to every cell
    typedef struct packed
    {
        logic   ins;
        logic   pop;
        logic   head_first;
        entry_t item;
    } sepq_ctrl_t;

endpackage

FILE: rtl/core/sorted_event_priority_queue.sv
// Output: the result is registered and appears in the cycle after the input transfer.
// Throughput: one insert or pop per cycle while in_ready is high; every cell compares
// against the broadcast event and shifts in parallel within that cycle.
// Reset: event count and output valid clear; slot contents are left as they are.
// ----------------------------------------------------------------------------
// sorted_event_priority_queue
// Time-ordered event queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module sorted_event_priority_queue
    import sepq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_data_reg;
    out_item_t        out_data_next;

    logic       in_fire;
    logic       is_full;
    logic       is_empty;
    logic       ins_en;
    logic       pop_en;
    entry_t     item;
    entry_t     head;
    sepq_ctrl_t ctrl;

    entry_t cell_entry [QUEUE_DEPTH];
    logic   cell_place [QUEUE_DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign is_empty = count_reg == '0;
    assign ins_en   = in_fire && (in_data.op == OP_INSERT) && !is_full;
    assign pop_en   = in_fire && (in_data.op == OP_POP) && !is_empty;

    assign item.ev_time   = in_data.event_time;
    assign item.ev_node   = in_data.event_node;
    assign item.ev_action = in_data.event_action;

    assign ctrl.ins        = ins_en;
    assign ctrl.pop        = pop_en;
    assign ctrl.item       = item;
    assign ctrl.head_first = is_empty || (item.ev_time <= cell_entry[0].ev_time);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_entry;
            logic   left_place;
            entry_t right_entry;

            if (gi == 0)
            begin : g_first
                assign left_entry = item;
                assign left_place = 1'b0;
            end
            else
            begin : g_mid
                assign left_entry = cell_entry[gi-1];
                assign left_place = cell_place[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_entry = cell_entry[gi];
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[gi+1];
            end

            sepq_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .left_entry  (left_entry),
                .left_place  (left_place),
                .right_entry (right_entry),
                .entry       (cell_entry[gi]),
                .place       (cell_place[gi])
            );
        end
    endgenerate

    // head and count as they stand after this transfer
    always_comb
    begin
        count_next = count_reg;
        head       = cell_entry[0];
        if (ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
            if (ctrl.head_first)
            begin
                head = item;
            end
        end
        else if (pop_en)
        begin
            count_next = count_reg - CNT_W'(1);
            head       = cell_entry[1];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_fire)
        begin
            out_valid_next            = 1'b1;
            out_data_next.head_valid  = count_next != '0;
            out_data_next.head_time   = (count_next != '0) ? head.ev_time : '0;
            out_data_next.head_node   = (count_next != '0) ? head.ev_node : '0;
            out_data_next.head_action = (count_next != '0) && head.ev_action;
            out_data_next.entry_count = COUNT_W'(count_next);
            out_data_next.underflow   = (in_data.op == OP_POP) && is_empty;
            out_data_next.overflow    = (in_data.op == OP_INSERT) && is_full;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("event count above depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.op == OP_INSERT) && is_full)
        |=> (count_reg == $past(count_reg)) && out_valid && out_data.overflow)
        else $error("insert into full queue not dropped");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.op == OP_POP) && is_empty)
        |=> is_empty && out_valid && out_data.underflow && !out_data.head_valid)
        else $error("pop on empty queue not flagged");
`endif

endmodule

FILE: rtl/core/sepq_cell.sv
// ----------------------------------------------------------------------------
// sepq_cell
// One slot of the sorted queue: compares the broadcast event with its own,
// then holds, takes the new event, or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module sepq_cell
    import sepq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
)
(
    input  logic             clk,
    input  sepq_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] count,
    input  entry_t           left_entry,
    input  logic             left_place,
    input  entry_t           right_entry,
    output entry_t           entry,
    output logic             place
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid;

    assign valid = count > CNT_W'(IDX);

    // place: the new event goes at or before this slot
    generate
        if (IDX == 0)
        begin : g_head
            assign place = ctrl.head_first;
        end
        else
        begin : g_body
            assign place = ctrl.head_first || !valid ||
                           (entry_reg.ev_time > ctrl.item.ev_time);
        end
    endgenerate

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (left_place)
            begin
                entry_next = left_entry;
            end
            else if (place)
            begin
                entry_next = ctrl.item;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
